/* rtl/bpa_pkg.sv */
// ---------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the bitmap page allocator
// Command and status codes, payload field widths and register map.
// ---------------------------------------------------------------------------
package bpa_pkg;

   localparam int CMD_W       = 2;
   localparam int ADDR_IN_W   = 32;
   localparam int PAGE_ADDR_W = 27;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 16;
   localparam int MEM_KB_W    = 22;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [MEM_KB_W-1:0] MEM_KB_RESET = 22'd131072;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_INIT  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK           = 3'd0,
      STAT_OUT_OF_MEM   = 3'd1,
      STAT_UNALIGNED    = 3'd2,
      STAT_OUT_OF_RANGE = 3'd3,
      STAT_ALREADY_FREE = 3'd4
   } status_type;

   // register index as seen on paddr[2]
   typedef enum logic {
      REG_INSTALLED_KB = 1'b0
   } reg_index_type;

endpackage

/* rtl/bpa_req_if.sv */
// ---------------------------------------------------------------------------
// bpa_req_if: command channel of the bitmap page allocator
// Valid/ready channel carrying one command and its address.
// ---------------------------------------------------------------------------
interface bpa_req_if;
   import bpa_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [ADDR_IN_W-1:0] address;

   modport source (output valid, command, address, input ready);
   modport sink   (input valid, command, address, output ready);

endinterface

/* rtl/bpa_rsp_if.sv */
// ---------------------------------------------------------------------------
// bpa_rsp_if: result channel of the bitmap page allocator
// Valid/ready channel carrying page address, status and page counts.
// ---------------------------------------------------------------------------
interface bpa_rsp_if;
   import bpa_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [PAGE_ADDR_W-1:0] page_address;
   logic [STATUS_W-1:0]    status;
   logic [COUNT_W-1:0]     free_count;
   logic [COUNT_W-1:0]     page_total;

   modport source (output valid, page_address, status, free_count, page_total, input ready);
   modport sink   (input valid, page_address, status, free_count, page_total, output ready);

endinterface

/* rtl/bpa_map_ram.sv */
// ---------------------------------------------------------------------------
// bpa_map_ram: usage map storage
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module bpa_map_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [31:0]       wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [31:0]       rdata
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/bpa_csr.sv */
// ---------------------------------------------------------------------------
// bpa_csr: APB register file
// Holds the installed memory size used by the init command.
// ---------------------------------------------------------------------------
module bpa_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bpa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bpa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [bpa_pkg::MEM_KB_W-1:0]    installed_kb
);
   import bpa_pkg::*;

   logic [MEM_KB_W-1:0] mem_kb_ff;
   logic [MEM_KB_W-1:0] mem_kb_in;
   logic                sel_kb;

   assign sel_kb = (paddr[2] == REG_INSTALLED_KB);

   always_comb begin
      mem_kb_in = mem_kb_ff;
      if (psel && penable && pwrite && sel_kb) begin
         mem_kb_in = pwdata[MEM_KB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_kb_ff <= MEM_KB_RESET;
      end else begin
         mem_kb_ff <= mem_kb_in;
      end
   end

   assign pready       = 1'b1;
   assign prdata       = sel_kb ? CSR_DATA_W'(mem_kb_ff) : '0;
   assign installed_kb = mem_kb_ff;

endmodule

/* rtl/bpa_engine.sv */
// ---------------------------------------------------------------------------
// bpa_engine: command sequencer of the page allocator
// Clears the map, scans it for the first free page and does read-modify-
// write on single map words; keeps the page counts and the result register.
// ---------------------------------------------------------------------------
module bpa_engine #(
   parameter int MAX_PAGE_COUNT     = 32768,
   parameter int PAGE_BYTES         = 4096,
   parameter int RESERVED_LOW_PAGES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   bpa_req_if.sink                       req_ch,
   bpa_rsp_if.source                     rsp_ch,
   input  logic [bpa_pkg::MEM_KB_W-1:0]  installed_kb
);
   import bpa_pkg::*;

   localparam int MAP_WORDS  = (MAX_PAGE_COUNT + 31) / 32;
   localparam int WORD_W     = $clog2(MAP_WORDS);
   localparam int CNT_W      = $clog2(MAX_PAGE_COUNT + 1);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);   // page size is a power of two
   localparam int MW         = CNT_W + 6;
   localparam int RST_RAW    = (131072 * 1024) / PAGE_BYTES;
   localparam int RST_TOTAL  = (RST_RAW > MAX_PAGE_COUNT) ? MAX_PAGE_COUNT : RST_RAW;
   localparam int RST_RSV    = (RESERVED_LOW_PAGES > RST_TOTAL) ? RST_TOTAL
                                                                 : RESERVED_LOW_PAGES;
   localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_CLEAR    = 6'b000010,
      S_SCAN     = 6'b000100,
      S_FREE_RD  = 6'b001000,
      S_FREE_CHK = 6'b010000,
      S_RESP     = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_IN_W-1:0]   addr_ff, addr_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [PAGE_ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [CNT_W-1:0]       managed_ff, managed_in;
   logic [CNT_W-1:0]       in_use_ff, in_use_in;
   logic [WORD_W:0]        scan_addr_ff, scan_addr_in;
   logic                   rd_pending_ff, rd_pending_in;
   logic [WORD_W-1:0]      rd_word_ff, rd_word_in;
   logic [WORD_W-1:0]      clr_addr_ff, clr_addr_in;
   logic                   clr_resp_ff, clr_resp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PAGE_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]     rsp_free_ff, rsp_free_in;
   logic [COUNT_W-1:0]     rsp_total_ff, rsp_total_in;

   logic                   map_we, map_re;
   logic [WORD_W-1:0]      map_waddr, map_raddr;
   logic [31:0]            map_wdata, map_rdata;

   logic [31:0]            kb_bytes;
   logic [31:0]            init_raw;
   logic [CNT_W-1:0]       init_total;
   logic [CNT_W-1:0]       reserve;
   logic [WORD_W:0]        word_limit;
   logic                   can_issue;
   logic [31:0]            free_bits;
   logic [4:0]             free_idx;
   logic [WORD_W+4:0]      alloc_page;
   logic [31:0]            free_pidx;
   logic                   free_unaligned;
   logic                   free_range;
   logic [4:0]             free_bit;

   // bits of word w that belong to pages below lim
   function automatic logic [31:0] word_mask(input logic [WORD_W-1:0] w,
                                             input logic [CNT_W-1:0] lim);
      logic [MW-1:0] base;
      logic [MW-1:0] limx;
      logic [MW-1:0] rem;
      logic [31:0]   m;
      base = MW'({w, 5'd0});
      limx = MW'(lim);
      rem  = limx - base;
      if (base >= limx) begin
         m = '0;
      end else if (rem >= MW'(32)) begin
         m = '1;
      end else begin
         m = ~(32'hFFFF_FFFF << rem[4:0]);
      end
      return m;
   endfunction

   bpa_map_ram #(
      .DEPTH  (MAP_WORDS),
      .ADDR_W (WORD_W)
   ) u_map (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .re    (map_re),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   assign kb_bytes   = 32'(installed_kb) << 10;
   assign init_raw   = kb_bytes >> PAGE_SHIFT;
   assign init_total = (init_raw > 32'(MAX_PAGE_COUNT)) ? CNT_W'(MAX_PAGE_COUNT)
                                                        : CNT_W'(init_raw);
   assign reserve    = (32'(managed_ff) < 32'(RESERVED_LOW_PAGES)) ? managed_ff
                                                                   : CNT_W'(RESERVED_LOW_PAGES);
   assign word_limit = (WORD_W + 1)'(((CNT_W + 1)'(managed_ff) + (CNT_W + 1)'(31)) >> 5);
   assign can_issue  = (scan_addr_ff < word_limit);
   assign free_bits  = ~map_rdata & word_mask(rd_word_ff, managed_ff);

   always_comb begin
      free_idx = '0;
      for (int i = 31; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_idx = 5'(i);
         end
      end
   end

   assign alloc_page     = {rd_word_ff, free_idx};
   assign free_pidx      = addr_ff >> PAGE_SHIFT;
   assign free_unaligned = (addr_ff[PAGE_SHIFT-1:0] != '0);
   assign free_range     = (33'(free_pidx) >= 33'(managed_ff));
   assign free_bit       = free_pidx[4:0];

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      managed_in    = managed_ff;
      in_use_in     = in_use_ff;
      scan_addr_in  = scan_addr_ff;
      rd_pending_in = rd_pending_ff;
      rd_word_in    = rd_word_ff;
      clr_addr_in   = clr_addr_ff;
      clr_resp_in   = clr_resp_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_total_in  = rsp_total_ff;
      map_we        = 1'b0;
      map_waddr     = rd_word_ff;
      map_wdata     = '0;
      map_re        = 1'b0;
      map_raddr     = scan_addr_ff[WORD_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               addr_in       = req_ch.address;
               res_status_in = STAT_OK;
               res_addr_in   = '0;
               case (req_ch.command)
                  CMD_ALLOC: begin
                     scan_addr_in  = '0;
                     rd_pending_in = 1'b0;
                     state_in      = S_SCAN;
                  end
                  CMD_FREE: begin
                     state_in = S_FREE_RD;
                  end
                  CMD_INIT: begin
                     // count restarts from zero so it never exceeds the new total
                     managed_in  = init_total;
                     in_use_in   = '0;
                     clr_addr_in = '0;
                     clr_resp_in = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_addr_ff;
            map_wdata = word_mask(clr_addr_ff, reserve);
            in_use_in = reserve;
            if (clr_addr_ff == LAST_WORD) begin
               clr_resp_in = 1'b0;
               state_in    = clr_resp_ff ? S_RESP : S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end

         S_SCAN: begin
            // reads are issued back to back; a hit abandons the word in flight
            if (can_issue) begin
               map_re        = 1'b1;
               scan_addr_in  = scan_addr_ff + 1'b1;
               rd_word_in    = scan_addr_ff[WORD_W-1:0];
               rd_pending_in = 1'b1;
            end else begin
               rd_pending_in = 1'b0;
            end
            if (rd_pending_ff && (free_bits != '0)) begin
               map_we        = 1'b1;
               map_waddr     = rd_word_ff;
               map_wdata     = map_rdata | (32'd1 << free_idx);
               in_use_in     = in_use_ff + 1'b1;
               res_addr_in   = PAGE_ADDR_W'({alloc_page, PAGE_SHIFT'(0)});
               rd_pending_in = 1'b0;
               state_in      = S_RESP;
            end else if (!can_issue) begin
               res_status_in = STAT_OUT_OF_MEM;
               state_in      = S_RESP;
            end
         end

         S_FREE_RD: begin
            if (free_unaligned) begin
               res_status_in = STAT_UNALIGNED;
               state_in      = S_RESP;
            end else if (free_range) begin
               res_status_in = STAT_OUT_OF_RANGE;
               state_in      = S_RESP;
            end else begin
               map_re    = 1'b1;
               map_raddr = WORD_W'(free_pidx >> 5);
               state_in  = S_FREE_CHK;
            end
         end

         S_FREE_CHK: begin
            if (!map_rdata[free_bit]) begin
               res_status_in = STAT_ALREADY_FREE;
            end else begin
               map_we    = 1'b1;
               map_waddr = WORD_W'(free_pidx >> 5);
               map_wdata = map_rdata & ~(32'd1 << free_bit);
               in_use_in = in_use_ff - 1'b1;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_free_in   = COUNT_W'(managed_ff - in_use_ff);
               rsp_total_in  = COUNT_W'(managed_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         managed_ff    <= CNT_W'(RST_TOTAL);
         in_use_ff     <= CNT_W'(RST_RSV);
         clr_addr_ff   <= '0;
         clr_resp_ff   <= 1'b0;
         rd_pending_ff <= 1'b0;
         scan_addr_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         managed_ff    <= managed_in;
         in_use_ff     <= in_use_in;
         clr_addr_ff   <= clr_addr_in;
         clr_resp_ff   <= clr_resp_in;
         rd_pending_ff <= rd_pending_in;
         scan_addr_ff  <= scan_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rd_word_ff    <= rd_word_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.page_address = rsp_addr_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.free_count   = rsp_free_ff;
   assign rsp_ch.page_total   = rsp_total_ff;

   a_in_use_bounded: assert property (@(posedge clock) disable iff (reset)
      in_use_ff <= managed_ff)
      else $error("pages in use exceed managed pages");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff != S_IDLE)
      else $error("accepted transaction did not start processing");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      map_we && map_re |-> map_waddr != map_raddr)
      else $error("map read and write to the same word in one cycle");

endmodule

/* rtl/bitmap_page_allocator.sv */
// ---------------------------------------------------------------------------
// bitmap_page_allocator: first-fit page allocator over a one-bit usage map
// Commands arrive on req_ch (allocate, free, reinitialise); each produces one
// result transaction on rsp_ch with page address, status and page counts.
// The page map sits in a 32-bit wide RAM, one word per 32 pages; the memory
// size used by reinitialise is programmed over the APB port (register 0).
//
// Usage notes:
//  - One command is processed at a time; req_ch.ready is high in idle, also
//    while a finished result still waits in the output register.
//  - Allocate: map words are read in order through the RAM read port, one word
//    per cycle, up to the word holding the first free page; out of memory is
//    found once all ceil(total / 32) words have been read.
//  - Free: one read-modify-write of a map word; unaligned or out-of-range addresses skip the map access.
//  - Reinitialise: rewrites every word of the whole map
//    ((MAX_PAGE_COUNT + 31) / 32 words, 1024 by default).
//  - After reset the same clearing pass runs, without a result, with
//    req_ch.ready low; APB writes are taken throughout.
//  - A stalled rsp_ch holds its result; the next result waits until taken.
// ---------------------------------------------------------------------------
module bitmap_page_allocator #(
   parameter int MAX_PAGE_COUNT     = 32768,
   parameter int PAGE_BYTES         = 4096,
   parameter int RESERVED_LOW_PAGES = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   bpa_req_if.sink                         req_ch,
   bpa_rsp_if.source                       rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bpa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bpa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import bpa_pkg::*;

   logic [MEM_KB_W-1:0] installed_kb;

   bpa_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .installed_kb (installed_kb)
   );

   bpa_engine #(
      .MAX_PAGE_COUNT     (MAX_PAGE_COUNT),
      .PAGE_BYTES         (PAGE_BYTES),
      .RESERVED_LOW_PAGES (RESERVED_LOW_PAGES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .installed_kb (installed_kb)
   );

endmodule
